@@ design/bb3_pkg.sv @@
package bb3_pkg;

   // Longest image row that the line store holds.
   localparam int MAX_LINE_WIDTH = 1024;
   localparam int COL_W          = $clog2(MAX_LINE_WIDTH);

   // Fixed field and register widths.
   localparam int CHAN_W   = 8;
   localparam int PIX_W    = 3 * CHAN_W;
   localparam int WIDTH_W  = 11;
   localparam int HEIGHT_W = 16;
   localparam int CSR_IDX_W  = 8;
   localparam int CSR_DATA_W = 16;

   // Neighbourhood sums: up to nine channel values and a count of one to nine.
   localparam int SUM_W   = 12;
   localparam int COUNT_W = 4;
   localparam int NUM_W   = SUM_W + 1;

   // Reciprocal scaling for the rounded mean.
   localparam int RECIP_W     = 17;
   localparam int RECIP_SHIFT = 17;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_WIDTH  = 8'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_HEIGHT = 8'd1;

   // One pixel, red in the lowest bits.
   typedef struct packed {
      logic [CHAN_W-1:0] blue;
      logic [CHAN_W-1:0] green;
      logic [CHAN_W-1:0] red;
   } pixel_type;

   // Per-channel neighbourhood sums.
   typedef struct packed {
      logic [SUM_W-1:0] blue;
      logic [SUM_W-1:0] green;
      logic [SUM_W-1:0] red;
   } sum_type;

   // Request to the mean unit: the sums and the number of neighbours.
   typedef struct packed {
      sum_type            sum;
      logic [COUNT_W-1:0] count;
   } mean_req_type;

   // What one accepted pixel has to produce, worked out when it is taken.
   typedef struct packed {
      logic do_first;
      logic do_edge;
      logic top_ok;
      logic bot_ok;
      logic col_ge1;
      logic col_ge2;
      logic last_row;
   } job_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOAD,
      ST_SUM,
      ST_MUL,
      ST_EMIT
   } state_type;

   // ceil(2^17 / (2 * count)); with numerators below 4600 the floor of the
   // scaled product equals the exact integer quotient.
   function automatic logic [RECIP_W-1:0] recip_of(input logic [COUNT_W-1:0] count);
      logic [RECIP_W-1:0] m;
      case (count)
         4'd1:    m = 17'd65536;
         4'd2:    m = 17'd32768;
         4'd3:    m = 17'd21846;
         4'd4:    m = 17'd16384;
         4'd5:    m = 17'd13108;
         4'd6:    m = 17'd10923;
         4'd7:    m = 17'd9363;
         4'd8:    m = 17'd8192;
         4'd9:    m = 17'd7282;
         default: m = '0;
      endcase
      return m;
   endfunction

endpackage

@@ design/bb3_ram.sv @@
module bb3_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Single write port and one registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ design/bb3_mean.sv @@
module bb3_mean (
   input  logic                 clock,
   input  bb3_pkg::mean_req_type mean_req,
   output bb3_pkg::pixel_type    mean_pix
);
   import bb3_pkg::*;

   logic [RECIP_W-1:0]       recip;
   logic [NUM_W-1:0]         num_red;
   logic [NUM_W-1:0]         num_green;
   logic [NUM_W-1:0]         num_blue;
   logic [NUM_W+RECIP_W-1:0] prod_red;
   logic [NUM_W+RECIP_W-1:0] prod_green;
   logic [NUM_W+RECIP_W-1:0] prod_blue;
   pixel_type                pix_ff;

   // Rounded half up: (2*sum + count) / (2*count), by reciprocal multiplication.
   always_comb begin
      recip      = recip_of(mean_req.count);
      num_red    = {mean_req.sum.red, 1'b0} + NUM_W'(mean_req.count);
      num_green  = {mean_req.sum.green, 1'b0} + NUM_W'(mean_req.count);
      num_blue   = {mean_req.sum.blue, 1'b0} + NUM_W'(mean_req.count);
      prod_red   = (NUM_W+RECIP_W)'(num_red) * (NUM_W+RECIP_W)'(recip);
      prod_green = (NUM_W+RECIP_W)'(num_green) * (NUM_W+RECIP_W)'(recip);
      prod_blue  = (NUM_W+RECIP_W)'(num_blue) * (NUM_W+RECIP_W)'(recip);
   end

   // The quotient is registered straight after the multipliers.
   always_ff @(posedge clock) begin
      pix_ff.red   <= prod_red[RECIP_SHIFT +: CHAN_W];
      pix_ff.green <= prod_green[RECIP_SHIFT +: CHAN_W];
      pix_ff.blue  <= prod_blue[RECIP_SHIFT +: CHAN_W];
   end

   assign mean_pix = pix_ff;

endmodule

@@ design/box_blur_3x3_edge_aware.sv @@
// Edge-aware 3x3 box blur over a raster stream of 24-bit RGB pixels.
// Input transactions on req_*: tdata carries red, green and blue; tuser set
// marks a drain item. After the last image row the host sends one row of
// drain items to flush the final output row. Drain items during the image are
// taken and dropped.
// Output transactions on rsp_*: the blurred pixel of row r-1, column c-1 for
// each input pixel (r, c) with r, c > 0, plus the right-edge pixel at the end
// of a row; tlast marks the last result of one input, tuser the final pixel.
// Image width and height are written on csr_* while the stream is idle; a
// write to either register also restarts the image at row 0, column 0.
// Structure: each pixel is handled by a small sequencer around one line RAM
// (read, then write back the same entry) and a shared reciprocal mean unit.
// An input without a result passes the load state only; each result adds the
// sum, multiply and emit states, through the sum, mean and output registers.
// A dropped drain item leaves the sequencer idle; only idle takes new input.
// A stalled receiver holds the output register; the next input is still
// taken and worked until its own result needs that register.
// Reset is synchronous: sequencer, positions and registers return to their
// defaults at once; the line RAM needs no clearing.
module box_blur_3x3_edge_aware (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // req_tdata: red_in[7:0], green_in[15:8], blue_in[23:16]
   input  logic [bb3_pkg::PIX_W-1:0]        req_tdata,
   // req_tuser: kind[0]
   input  logic                             req_tuser,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // rsp_tdata: red_out[7:0], green_out[15:8], blue_out[23:16]
   output logic [bb3_pkg::PIX_W-1:0]        rsp_tdata,
   output logic                             rsp_tlast,
   // rsp_tuser: end_of_image[0]
   output logic                             rsp_tuser,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [bb3_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [bb3_pkg::CSR_DATA_W-1:0]   csr_data
);
   import bb3_pkg::*;

   state_type             state_ff, state_in;
   logic [WIDTH_W-1:0]    width_ff;
   logic [HEIGHT_W-1:0]   height_ff;
   logic [COL_W-1:0]      col_pos_ff;
   logic [HEIGHT_W-1:0]   row_pos_ff;
   logic [COL_W-1:0]      col_ff;
   pixel_type             cur_ff;
   job_type               job_ff, job_in;
   logic                  edge_phase_ff, edge_phase_in;
   pixel_type             win_ff [3][3];
   mean_req_type          mean_req_ff, mean_req_in;
   pixel_type             mean_pix;
   logic                  rsp_valid_ff;
   pixel_type             rsp_pix_ff;
   logic                  rsp_last_ff;
   logic                  rsp_user_ff;

   logic [COL_W-1:0]      w_last;
   logic [HEIGHT_W-1:0]   h_eff;
   logic                  drain_row;
   logic                  at_last;
   logic                  csr_write;
   logic                  in_accept;
   logic                  in_take;
   logic                  out_free;
   logic                  out_load;
   logic                  ram_rd_en;
   logic                  ram_wr_en;
   logic [2*PIX_W-1:0]    ram_rd_data;
   logic [2*PIX_W-1:0]    ram_wr_data;
   logic [2:0]            row_mask;
   logic [2:0]            col_mask;

   // Effective image size and the position of the incoming pixel.
   always_comb begin
      if (width_ff == '0) begin
         w_last = '0;
      end else if (int'(width_ff) > MAX_LINE_WIDTH) begin
         w_last = COL_W'(MAX_LINE_WIDTH - 1);
      end else begin
         w_last = COL_W'(width_ff - WIDTH_W'(1));
      end
      h_eff     = (height_ff == '0) ? HEIGHT_W'(1) : height_ff;
      drain_row = (row_pos_ff >= h_eff);
      at_last   = (col_pos_ff == w_last);
   end

   assign csr_write = csr_valid && csr_ready;
   assign csr_ready = 1'b1;
   assign in_accept = req_tvalid && req_tready;
   // A drain item inside the image is taken and dropped.
   assign in_take   = in_accept && !(req_tuser && !drain_row);
   assign out_free  = !rsp_valid_ff || rsp_tready;

   // Work to be done for this pixel.
   always_comb begin
      job_in.do_first = (row_pos_ff != '0) && (col_pos_ff != '0);
      job_in.do_edge  = (row_pos_ff != '0) && at_last;
      job_in.top_ok   = (row_pos_ff > HEIGHT_W'(1));
      job_in.bot_ok   = !drain_row;
      job_in.col_ge1  = (col_pos_ff != '0);
      job_in.col_ge2  = (col_pos_ff > COL_W'(1));
      job_in.last_row = drain_row;
   end

   // Sequencer: next state and strobes.
   always_comb begin
      state_in      = state_ff;
      edge_phase_in = edge_phase_ff;
      req_tready    = 1'b0;
      ram_rd_en     = 1'b0;
      ram_wr_en     = 1'b0;
      out_load      = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (in_take) begin
               ram_rd_en = 1'b1;
               state_in  = ST_LOAD;
            end
         end
         ST_LOAD: begin
            ram_wr_en = 1'b1;
            if (job_ff.do_first) begin
               edge_phase_in = 1'b0;
               state_in      = ST_SUM;
            end else if (job_ff.do_edge) begin
               edge_phase_in = 1'b1;
               state_in      = ST_SUM;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_SUM: begin
            state_in = ST_MUL;
         end
         ST_MUL: begin
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (out_free) begin
               out_load = 1'b1;
               if (!edge_phase_ff && job_ff.do_edge) begin
                  edge_phase_in = 1'b1;
                  state_in      = ST_SUM;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         edge_phase_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         edge_phase_ff <= edge_phase_in;
      end
   end

   // Configuration registers and raster position.
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff   <= WIDTH_W'(MAX_LINE_WIDTH);
         height_ff  <= HEIGHT_W'(1);
         col_pos_ff <= '0;
         row_pos_ff <= '0;
      end else if (csr_write) begin
         if (csr_index == CSR_IMAGE_WIDTH) begin
            width_ff   <= csr_data[WIDTH_W-1:0];
            col_pos_ff <= '0;
            row_pos_ff <= '0;
         end else if (csr_index == CSR_IMAGE_HEIGHT) begin
            height_ff  <= csr_data[HEIGHT_W-1:0];
            col_pos_ff <= '0;
            row_pos_ff <= '0;
         end
      end else if (in_take) begin
         if (at_last) begin
            col_pos_ff <= '0;
            row_pos_ff <= (row_pos_ff == h_eff) ? '0 : row_pos_ff + HEIGHT_W'(1);
         end else begin
            col_pos_ff <= col_pos_ff + COL_W'(1);
         end
      end
   end

   // Pixel held for the write-back; the drain row enters as black.
   always_ff @(posedge clock) begin
      if (in_take) begin
         col_ff <= col_pos_ff;
         job_ff <= job_in;
         cur_ff <= drain_row ? '0 : pixel_type'(req_tdata);
      end
   end

   // Line RAM entry: upper row in the high half, middle row in the low half.
   assign ram_wr_data = {ram_rd_data[PIX_W-1:0], PIX_W'(cur_ff)};

   bb3_ram #(
      .WIDTH (2 * PIX_W),
      .DEPTH (MAX_LINE_WIDTH)
   ) u_line_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (col_ff),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (col_pos_ff),
      .rd_data (ram_rd_data)
   );

   // Window shifts left by one column when the line RAM data arrives.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
               win_ff[i][j] <= '0;
            end
         end
      end else if (state_ff == ST_LOAD) begin
         for (int i = 0; i < 3; i++) begin
            win_ff[i][0] <= win_ff[i][1];
            win_ff[i][1] <= win_ff[i][2];
         end
         win_ff[0][2] <= pixel_type'(ram_rd_data[2*PIX_W-1:PIX_W]);
         win_ff[1][2] <= pixel_type'(ram_rd_data[PIX_W-1:0]);
         win_ff[2][2] <= cur_ff;
      end
   end

   // Masked neighbourhood sums for the result being formed.
   always_comb begin
      row_mask = {job_ff.bot_ok, 1'b1, job_ff.top_ok};
      if (edge_phase_ff) begin
         col_mask = {1'b1, job_ff.col_ge1, 1'b0};
      end else begin
         col_mask = {1'b1, 1'b1, job_ff.col_ge2};
      end
      mean_req_in = '0;
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            if (row_mask[i] && col_mask[j]) begin
               mean_req_in.sum.red   = mean_req_in.sum.red + SUM_W'(win_ff[i][j].red);
               mean_req_in.sum.green = mean_req_in.sum.green + SUM_W'(win_ff[i][j].green);
               mean_req_in.sum.blue  = mean_req_in.sum.blue + SUM_W'(win_ff[i][j].blue);
               mean_req_in.count     = mean_req_in.count + COUNT_W'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_SUM) begin
         mean_req_ff <= mean_req_in;
      end
   end

   bb3_mean u_mean (
      .clock    (clock),
      .mean_req (mean_req_ff),
      .mean_pix (mean_pix)
   );

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_pix_ff  <= mean_pix;
         rsp_last_ff <= edge_phase_ff || !job_ff.do_edge;
         rsp_user_ff <= edge_phase_ff && job_ff.last_row;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = PIX_W'(rsp_pix_ff);
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule

@@ design/bb3_checker.sv @@
module bb3_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             rsp_tvalid,
   input logic                             rsp_tready,
   input logic [bb3_pkg::PIX_W-1:0]        rsp_tdata,
   input logic                             rsp_tlast,
   input logic                             rsp_tuser
);
   import bb3_pkg::*;

   // A result offered but not taken stays offered.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("result withdrawn while stalled");

   // A stalled result keeps its payload.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata) && $stable(rsp_tlast)
                                    && $stable(rsp_tuser))
      else $error("result payload changed while stalled");

   // The final pixel of the image is always the last result of its input.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tlast)
      else $error("end of image without end of run");

   // Nothing is offered in the cycle after reset.
   assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result offered straight after reset");

endmodule

bind box_blur_3x3_edge_aware bb3_checker u_bb3_checker (.*);
